/* rtl/core/bff_pkg.sv */
// Package for the boundary flood fill block: sequencer states, item kinds,
// field widths and default grid parameters. No dependencies.
package bff_pkg;

  localparam int unsigned GridWidthDefault  = 64;
  localparam int unsigned GridHeightDefault = 64;
  localparam int unsigned ColorBitsDefault  = 8;

  localparam int unsigned PosBits   = 6;
  localparam int unsigned InColBits = 8;
  localparam int unsigned OutRvBits = 8;
  localparam int unsigned InDataW   = 32;
  localparam int unsigned OutDataW  = 16;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_FILL  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_WAIT,
    ST_TRY_RD,
    ST_TRY_CHK,
    ST_NEIGH,
    ST_POP,
    ST_POP_WAIT,
    ST_DONE
  } state_e;

endpackage

/* rtl/core/boundary_flood_fill.sv */
// Top level of the boundary flood fill block: pixel memory, coordinate stack
// and the sequencer that walks a fill. Depends on bff_pkg.
//
// After reset the block clears all GRID_HEIGHT * 2**clog2(GRID_WIDTH)
// locations of the pixel memory (4096 at the default 64 x 64 grid) and
// accepts no word meanwhile. It takes one item at a time. A write goes
// straight to the done state and a read passes a read wait state first;
// each then hands over its result word. In a fill, each popped pixel needs
// a stack read, then for each of its four neighbours a step to compute it
// and, if it lies in the grid, a read and a test of it. Exactly one result
// word follows every input word; the output register lets the next item
// start while that word waits.
module boundary_flood_fill #(
  parameter int unsigned GRID_WIDTH  = bff_pkg::GridWidthDefault,
  parameter int unsigned GRID_HEIGHT = bff_pkg::GridHeightDefault,
  parameter int unsigned COLOR_BITS  = bff_pkg::ColorBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // pos_x[5:0], pos_y[11:6], color[19:12], edge_color[27:20], zero pad above
  input  logic [bff_pkg::InDataW-1:0]   s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // read_value[7:0], seed_changed[8], zero pad above
  output logic [bff_pkg::OutDataW-1:0]  m_axis_tdata
);
  import bff_pkg::*;

  localparam int unsigned XW    = $clog2(GRID_WIDTH);
  localparam int unsigned YW    = $clog2(GRID_HEIGHT);
  localparam int unsigned AW    = XW + YW;
  localparam int unsigned Depth = GRID_HEIGHT << XW;
  localparam int unsigned Cells = GRID_WIDTH * GRID_HEIGHT;
  localparam int unsigned STW   = $clog2(Cells);
  localparam int unsigned SPW   = $clog2(Cells + 1);

  state_e state_q, state_d;

  logic [XW-1:0]         cx_q, cx_d, nx_q, nx_d;
  logic [YW-1:0]         cy_q, cy_d, ny_q, ny_d;
  logic [1:0]            dir_q, dir_d;
  logic [COLOR_BITS-1:0] fill_q, fill_d, edge_q, edge_d;
  logic [SPW-1:0]        sp_q, sp_d;
  logic                  first_q, first_d;
  logic                  seed_q, seed_d;
  logic [OutRvBits-1:0]  rv_q, rv_d;
  logic [AW-1:0]         clr_q, clr_d;
  logic                  out_valid_q;
  logic [OutRvBits-1:0]  out_rv_q;
  logic                  out_sc_q;

  logic [COLOR_BITS-1:0] pix_mem_q [Depth];
  logic [AW-1:0]         stk_mem_q [Cells];
  logic [COLOR_BITS-1:0] pix_rd_q;
  logic [AW-1:0]         stk_rd_q;

  logic                  pix_we, pix_re, stk_we, stk_re;
  logic [AW-1:0]         pix_waddr, pix_raddr, stk_wdata;
  logic [COLOR_BITS-1:0] pix_wdata;
  logic [STW-1:0]        stk_waddr, stk_raddr;

  // Input fields.
  kind_e                 in_kind;
  logic [PosBits-1:0]    in_x, in_y;
  logic [InColBits-1:0]  in_col, in_edge;
  logic [31:0]           col_w, edge_w;
  logic [COLOR_BITS-1:0] in_col_c, in_edge_c;
  logic                  in_inside;
  logic [XW-1:0]         in_xc;
  logic [YW-1:0]         in_yc;
  logic [31:0]           in_xw, in_yw;

  assign in_kind   = kind_e'(s_axis_tuser);
  assign in_x      = s_axis_tdata[5:0];
  assign in_y      = s_axis_tdata[11:6];
  assign in_col    = s_axis_tdata[19:12];
  assign in_edge   = s_axis_tdata[27:20];
  assign col_w     = 32'(in_col);
  assign edge_w    = 32'(in_edge);
  assign in_col_c  = col_w[COLOR_BITS-1:0];
  assign in_edge_c = edge_w[COLOR_BITS-1:0];
  assign in_xw     = 32'(in_x);
  assign in_yw     = 32'(in_y);
  assign in_xc     = in_xw[XW-1:0];
  assign in_yc     = in_yw[YW-1:0];
  assign in_inside = (in_xw < 32'(GRID_WIDTH)) && (in_yw < 32'(GRID_HEIGHT));

  // Neighbour of the current pixel in direction dir_q: right, left, down, up.
  logic [XW-1:0] nb_x;
  logic [YW-1:0] nb_y;
  logic          nb_ok;
  always_comb begin
    nb_x  = cx_q;
    nb_y  = cy_q;
    nb_ok = 1'b0;
    unique case (dir_q)
      2'd0: begin
        nb_x  = cx_q + 1'b1;
        nb_ok = (32'(cx_q) + 32'd1) < 32'(GRID_WIDTH);
      end
      2'd1: begin
        nb_x  = cx_q - 1'b1;
        nb_ok = (cx_q != '0);
      end
      2'd2: begin
        nb_y  = cy_q + 1'b1;
        nb_ok = (32'(cy_q) + 32'd1) < 32'(GRID_HEIGHT);
      end
      default: begin
        nb_y  = cy_q - 1'b1;
        nb_ok = (cy_q != '0);
      end
    endcase
  end

  logic paintable, out_free, stk_empty, clr_last;
  logic [OutRvBits+COLOR_BITS-1:0] pix_w;
  assign paintable = (pix_rd_q != edge_q) && (pix_rd_q != fill_q);
  assign out_free  = !out_valid_q || m_axis_tready;
  assign stk_empty = (sp_q == '0);
  assign clr_last  = (clr_q == AW'(Depth - 1));
  assign pix_w     = {{OutRvBits{1'b0}}, pix_rd_q};

  assign s_axis_tready = (state_q == ST_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (in_kind == KIND_READ && in_inside) begin
            state_d = ST_RD_WAIT;
          end else if (in_kind == KIND_FILL && in_inside) begin
            state_d = ST_TRY_RD;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_RD_WAIT: state_d = ST_DONE;
      ST_TRY_RD:  state_d = ST_TRY_CHK;
      ST_TRY_CHK: begin
        if (first_q || dir_q == 2'd3) state_d = ST_POP;
        else state_d = ST_NEIGH;
      end
      ST_NEIGH: begin
        if (nb_ok) state_d = ST_TRY_RD;
        else if (dir_q == 2'd3) state_d = ST_POP;
      end
      ST_POP: begin
        if (stk_empty) state_d = ST_DONE;
        else state_d = ST_POP_WAIT;
      end
      ST_POP_WAIT: state_d = ST_NEIGH;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    cx_d      = cx_q;
    cy_d      = cy_q;
    nx_d      = nx_q;
    ny_d      = ny_q;
    dir_d     = dir_q;
    fill_d    = fill_q;
    edge_d    = edge_q;
    sp_d      = sp_q;
    first_d   = first_q;
    seed_d    = seed_q;
    rv_d      = rv_q;
    clr_d     = clr_q;
    pix_we    = 1'b0;
    pix_re    = 1'b0;
    pix_waddr = {ny_q, nx_q};
    pix_raddr = {ny_q, nx_q};
    pix_wdata = fill_q;
    stk_we    = 1'b0;
    stk_re    = 1'b0;
    stk_waddr = sp_q[STW-1:0];
    stk_raddr = sp_q[STW-1:0] - 1'b1;
    stk_wdata = {ny_q, nx_q};
    unique case (state_q)
      ST_CLEAR: begin
        pix_we    = 1'b1;
        pix_waddr = clr_q;
        pix_wdata = '0;
        clr_d     = clr_q + 1'b1;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          nx_d    = in_xc;
          ny_d    = in_yc;
          fill_d  = in_col_c;
          edge_d  = in_edge_c;
          sp_d    = '0;
          first_d = 1'b1;
          seed_d  = 1'b0;
          rv_d    = '0;
          if (in_kind == KIND_WRITE && in_inside) begin
            pix_we    = 1'b1;
            pix_waddr = {in_yc, in_xc};
            pix_wdata = in_col_c;
          end
          if (in_kind == KIND_READ && in_inside) begin
            pix_re    = 1'b1;
            pix_raddr = {in_yc, in_xc};
          end
        end
      end
      ST_RD_WAIT: rv_d = pix_w[OutRvBits-1:0];
      ST_TRY_RD:  pix_re = 1'b1;
      ST_TRY_CHK: begin
        // Painting at push time keeps every pixel off the stack after its first visit.
        if (paintable) begin
          pix_we = 1'b1;
          if (sp_q != SPW'(Cells)) begin
            stk_we = 1'b1;
            sp_d   = sp_q + 1'b1;
          end
          if (first_q) seed_d = 1'b1;
        end
        first_d = 1'b0;
        if (!first_q && dir_q != 2'd3) dir_d = dir_q + 1'b1;
      end
      ST_NEIGH: begin
        if (nb_ok) begin
          nx_d = nb_x;
          ny_d = nb_y;
        end else if (dir_q != 2'd3) begin
          dir_d = dir_q + 1'b1;
        end
      end
      ST_POP: begin
        if (!stk_empty) begin
          stk_re = 1'b1;
          sp_d   = sp_q - 1'b1;
        end
      end
      ST_POP_WAIT: begin
        cx_d  = stk_rd_q[XW-1:0];
        cy_d  = stk_rd_q[AW-1:XW];
        dir_d = 2'd0;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      sp_q        <= '0;
      first_q     <= 1'b0;
      dir_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      sp_q    <= sp_d;
      first_q <= first_d;
      dir_q   <= dir_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    nx_q   <= nx_d;
    ny_q   <= ny_d;
    fill_q <= fill_d;
    edge_q <= edge_d;
    seed_q <= seed_d;
    rv_q   <= rv_d;
    if (state_q == ST_DONE && out_free) begin
      out_rv_q <= rv_q;
      out_sc_q <= seed_q;
    end
  end

  // Pixel memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (pix_we) pix_mem_q[pix_waddr] <= pix_wdata;
    if (pix_re) pix_rd_q <= pix_mem_q[pix_raddr];
  end

  // Coordinate stack.
  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem_q[stk_waddr] <= stk_wdata;
    if (stk_re) stk_rd_q <= stk_mem_q[stk_raddr];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - OutRvBits - 1){1'b0}}, out_sc_q, out_rv_q};

endmodule
